// ===== rtl/sac_pkg.sv =====
// Shared S-box tables, GF(16) arithmetic and round step functions for the block cipher.
`default_nettype none

package sac_pkg;

    localparam int unsigned BlockWidth = 16;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned NibWidth   = 4;

    localparam logic [ByteWidth-1:0]  Rcon1   = 8'h80;
    localparam logic [ByteWidth-1:0]  Rcon2   = 8'h30;
    localparam logic [NibWidth:0]     GfPoly  = 5'h13;
    localparam logic                  CmdEnc  = 1'b0;
    localparam logic                  CmdDec  = 1'b1;
    localparam logic [NibWidth-1:0]   MixDiag = 4'd1;
    localparam logic [NibWidth-1:0]   MixOff  = 4'd4;
    localparam logic [NibWidth-1:0]   InvDiag = 4'd9;
    localparam logic [NibWidth-1:0]   InvOff  = 4'd2;

    typedef logic [BlockWidth-1:0] block_t;
    typedef logic [ByteWidth-1:0]  byte_t;
    typedef logic [NibWidth-1:0]   nib_t;

    typedef struct packed {
        block_t k0;
        block_t k1;
        block_t k2;
    } round_keys_t;

    function automatic nib_t sbox_fwd(input nib_t n);
        nib_t r;
        case (n)
            4'h0: r = 4'd9;
            4'h1: r = 4'd4;
            4'h2: r = 4'd10;
            4'h3: r = 4'd11;
            4'h4: r = 4'd13;
            4'h5: r = 4'd1;
            4'h6: r = 4'd8;
            4'h7: r = 4'd5;
            4'h8: r = 4'd6;
            4'h9: r = 4'd2;
            4'hA: r = 4'd0;
            4'hB: r = 4'd3;
            4'hC: r = 4'd12;
            4'hD: r = 4'd14;
            4'hE: r = 4'd15;
            4'hF: r = 4'd7;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic nib_t sbox_inv(input nib_t n);
        nib_t r;
        case (n)
            4'h0: r = 4'd10;
            4'h1: r = 4'd5;
            4'h2: r = 4'd9;
            4'h3: r = 4'd11;
            4'h4: r = 4'd1;
            4'h5: r = 4'd7;
            4'h6: r = 4'd8;
            4'h7: r = 4'd15;
            4'h8: r = 4'd6;
            4'h9: r = 4'd0;
            4'hA: r = 4'd2;
            4'hB: r = 4'd3;
            4'hC: r = 4'd12;
            4'hD: r = 4'd4;
            4'hE: r = 4'd13;
            4'hF: r = 4'd14;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic block_t sub_nib_fwd(input block_t v);
        block_t r;
        for (int i = 0; i < 4; i++) begin
            r[i*NibWidth +: NibWidth] = sbox_fwd(v[i*NibWidth +: NibWidth]);
        end
        return r;
    endfunction

    function automatic block_t sub_nib_inv(input block_t v);
        block_t r;
        for (int i = 0; i < 4; i++) begin
            r[i*NibWidth +: NibWidth] = sbox_inv(v[i*NibWidth +: NibWidth]);
        end
        return r;
    endfunction

    // n1 and n3 trade places
    function automatic block_t swap_row(input block_t v);
        return {v[15:12], v[3:0], v[7:4], v[11:8]};
    endfunction

    function automatic nib_t gf16_mul(input nib_t a, input nib_t b);
        logic [NibWidth:0] acc;
        nib_t              r;
        acc = {1'b0, a};
        r   = '0;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                r = r ^ acc[NibWidth-1:0];
            end
            acc = {acc[NibWidth-1:0], 1'b0};
            if (acc[NibWidth]) begin
                acc = acc ^ GfPoly;
            end
        end
        return r;
    endfunction

    function automatic block_t mix_cols(input block_t v, input nib_t diag, input nib_t off);
        nib_t n0;
        nib_t n1;
        nib_t n2;
        nib_t n3;
        n0 = v[15:12];
        n1 = v[11:8];
        n2 = v[7:4];
        n3 = v[3:0];
        return {gf16_mul(n0, diag) ^ gf16_mul(n1, off),
                gf16_mul(n0, off)  ^ gf16_mul(n1, diag),
                gf16_mul(n2, diag) ^ gf16_mul(n3, off),
                gf16_mul(n2, off)  ^ gf16_mul(n3, diag)};
    endfunction

    function automatic byte_t sub_rot_byte(input byte_t b);
        return {sbox_fwd(b[3:0]), sbox_fwd(b[7:4])};
    endfunction

    function automatic round_keys_t expand_key(input block_t k);
        byte_t       w0;
        byte_t       w1;
        byte_t       w2;
        byte_t       w3;
        byte_t       w4;
        byte_t       w5;
        round_keys_t rk;
        w0 = k[15:8];
        w1 = k[7:0];
        w2 = w0 ^ Rcon1 ^ sub_rot_byte(w1);
        w3 = w2 ^ w1;
        w4 = w2 ^ Rcon2 ^ sub_rot_byte(w3);
        w5 = w4 ^ w3;
        rk.k0 = {w0, w1};
        rk.k1 = {w2, w3};
        rk.k2 = {w4, w5};
        return rk;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/simplified_aes_cipher.sv =====
// Top level: four-stage pipelined 16-bit block cipher with per-stage valid and stall handling.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  s_       | in        | s_valid / s_ready  | s_command, s_data_block
//  m_       | out       | m_valid / m_ready  | m_result_block
//  cfg_     | in        | cfg_we (no wait)   | cfg_wdata (cipher key)
//
// One beat per cycle sustained while m_ready holds high; four register stages (key add, half round,
// mix columns, final round), which each accepted beat passes through in that order before
// m_valid rises and the result can be taken.
// Round keys are expanded from cfg_wdata on the write and held in registers.
// A stall on m_ready only holds the stages that are occupied; empty stages still fill.
// Synchronous active-low reset empties the pipe and loads the keys for a zero key.
`default_nettype none

module simplified_aes_cipher (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire sac_pkg::block_t        cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_command,
    input  wire sac_pkg::block_t        s_data_block,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output sac_pkg::block_t             m_result_block
);
    import sac_pkg::*;

    round_keys_t rk_reg;

    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    logic   c1_reg, c2_reg, c3_reg;
    block_t d1_reg, d2_reg, d3_reg, d4_reg;
    block_t d1_next, d2_next, d3_next, d4_next;
    logic   ld1, ld2, ld3, ld4;

    // a stage may load when empty or when its contents move on this cycle
    assign ld4     = !v4_reg || m_ready;
    assign ld3     = !v3_reg || ld4;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign s_ready = ld1;

    always_comb begin
        d1_next = s_data_block ^ ((s_command == CmdDec) ? rk_reg.k2 : rk_reg.k0);
        if (c1_reg == CmdDec) begin
            d2_next = sub_nib_inv(swap_row(d1_reg)) ^ rk_reg.k1;
        end else begin
            d2_next = swap_row(sub_nib_fwd(d1_reg));
        end
        if (c2_reg == CmdDec) begin
            d3_next = mix_cols(d2_reg, InvDiag, InvOff);
        end else begin
            d3_next = mix_cols(d2_reg, MixDiag, MixOff) ^ rk_reg.k1;
        end
        if (c3_reg == CmdDec) begin
            d4_next = sub_nib_inv(swap_row(d3_reg)) ^ rk_reg.k0;
        end else begin
            d4_next = swap_row(sub_nib_fwd(d3_reg)) ^ rk_reg.k2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rk_reg <= expand_key('0);
        end else if (cfg_we) begin
            rk_reg <= expand_key(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            d1_reg <= d1_next;
            c1_reg <= s_command;
        end
        if (ld2) begin
            d2_reg <= d2_next;
            c2_reg <= c1_reg;
        end
        if (ld3) begin
            d3_reg <= d3_next;
            c3_reg <= c2_reg;
        end
        if (ld4) begin
            d4_reg <= d4_next;
        end
    end

    assign m_valid        = v4_reg;
    assign m_result_block = d4_reg;

endmodule

`default_nettype wire

// ===== rtl/sac_checker.sv =====
// Port-level checker for the cipher pipeline, bound to the top level.
`default_nettype none

module sac_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire sac_pkg::block_t     m_result_block
);
    import sac_pkg::*;

    // a held result beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_block))
        else $error("result beat dropped or changed while stalled");

    // reset empties the pipe
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // with no result waiting the whole pipe can move, so input is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output stage");

    // nothing can come out without something having gone in before
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 4))
        else $error("result beat appeared without a matching input beat");

endmodule

bind simplified_aes_cipher sac_checker u_sac_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_block (m_result_block)
);

`default_nettype wire
